[rtl/core/ffha_pkg.sv]
// Shared types and constants of the first-fit heap allocator.
`default_nettype none

package ffha_pkg;

  // Fixed geometry of the arena
  localparam int unsigned HEADER_BYTES = 48;
  localparam int unsigned PAGE_SHIFT   = 12;
  localparam int unsigned ALIGN_SHIFT  = 4;
  localparam int unsigned PAGE_BYTES   = 1 << PAGE_SHIFT;
  localparam int unsigned ALIGN_BYTES  = 1 << ALIGN_SHIFT;
  localparam int unsigned SPLIT_MIN    = HEADER_BYTES + ALIGN_BYTES;
  // Width of a page count for one request
  localparam int unsigned PG_W         = 34 - PAGE_SHIFT;
  // Arena ceiling of 2^44 bytes, in pages
  localparam logic [32:0] ARENA_PAGE_CAP = 33'd1 << (44 - PAGE_SHIFT);

  // Command codes
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  // Register indexes
  localparam logic REG_HEAP_READY  = 1'b0;
  localparam logic REG_ARENA_LIMIT = 1'b1;

  typedef enum logic [2:0] {
    ST_OK,
    ST_REJECTED,
    ST_EXHAUSTED,
    ST_BACKING,
    ST_IGNORED,
    ST_TABLE_FULL
  } status_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LATCH,
    OP_SETST,
    OP_ADV,
    OP_TAKE,
    OP_GSTART,
    OP_GSTEP,
    OP_WHOLE,
    OP_SPL_T,
    OP_SPL_B,
    OP_FIX,
    OP_GROW,
    OP_FTAKE,
    OP_WA_NEXT,
    OP_LOADN,
    OP_ABS,
    OP_WA,
    OP_SWAP,
    OP_LOADA,
    OP_PUB
  } dp_op_t;

  typedef struct packed {
    dp_op_t  op;
    status_t code;
  } dp_cmd_t;

  typedef struct packed {
    logic cur_nil;
    logic fit;
    logic split_want;
    logic g_done;
    logic g_nil;
    logic limit_bad;
    logic tail_nil;
    logic anext_nil;
    logic nnext_nil;
    logic aprev_nil;
    logic rd_free;
    logic off_hit;
    logic off_bad;
    logic zero_req;
    logic free_cmd;
    logic backing;
    logic out_busy;
  } dp_flags_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_START,
    S_A_WAIT,
    S_A_CHK,
    S_A_SPL,
    S_A_GRAB,
    S_A_WHOLE,
    S_A_WT,
    S_A_WB,
    S_G_CHK,
    S_G_GRAB,
    S_G_WR,
    S_F_WAIT,
    S_F_CHK,
    S_F_WB,
    S_N_WAIT,
    S_N_CHK,
    S_ABS1,
    S_WA1,
    S_P_START,
    S_P_WAIT,
    S_P_CHK,
    S_ABS2,
    S_WA2,
    S_FIX_WAIT,
    S_FIX,
    S_OUT
  } ctrl_state_t;

endpackage

`default_nettype wire

[rtl/core/ffha_ctrl.sv]
// Sequencer of the allocator: walks, slot scan, splits, growth and merges.
`default_nettype none

module ffha_ctrl
  import ffha_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire logic      heap_ready,
  input  wire dp_flags_t flags,
  output dp_cmd_t        cmd
);

  ctrl_state_t state, state_next;
  ctrl_state_t ret, ret_next;

  // Hold state and return point
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ret   <= S_OUT;
    end else begin
      state <= state_next;
      ret   <= ret_next;
    end
  end

  // Choose the next state
  always_comb begin
    state_next = state;
    ret_next   = ret;
    unique case (state)
      S_IDLE:     if (in_valid) state_next = S_START;
      S_START: begin
        if (!flags.free_cmd)
          state_next = (!heap_ready || flags.zero_req) ? S_OUT : S_A_WAIT;
        else
          state_next = (!heap_ready || flags.off_bad) ? S_OUT : S_F_WAIT;
      end
      S_A_WAIT:   state_next = flags.cur_nil ? S_G_CHK : S_A_CHK;
      S_A_CHK:    state_next = flags.fit ? S_A_SPL : S_A_WAIT;
      S_A_SPL:    state_next = flags.split_want ? S_A_GRAB : S_A_WHOLE;
      S_A_GRAB:   if (flags.g_done) state_next = flags.g_nil ? S_A_WHOLE : S_A_WT;
      S_A_WHOLE:  state_next = S_OUT;
      S_A_WT:     state_next = S_A_WB;
      S_A_WB: begin
        ret_next   = S_OUT;
        state_next = flags.anext_nil ? S_OUT : S_FIX_WAIT;
      end
      S_G_CHK:    state_next = flags.limit_bad ? S_OUT : S_G_GRAB;
      S_G_GRAB: begin
        if (flags.g_done)
          state_next = (flags.g_nil || !flags.backing) ? S_OUT : S_G_WR;
      end
      S_G_WR: begin
        ret_next   = S_OUT;
        state_next = flags.tail_nil ? S_OUT : S_FIX_WAIT;
      end
      S_F_WAIT:   state_next = flags.cur_nil ? S_OUT : S_F_CHK;
      S_F_CHK: begin
        if (flags.off_hit) state_next = flags.rd_free ? S_OUT : S_F_WB;
        else state_next = S_F_WAIT;
      end
      S_F_WB:     state_next = S_N_WAIT;
      S_N_WAIT:   state_next = flags.cur_nil ? S_P_START : S_N_CHK;
      S_N_CHK:    state_next = flags.rd_free ? S_ABS1 : S_P_START;
      S_ABS1:     state_next = S_WA1;
      S_WA1: begin
        ret_next   = S_P_START;
        state_next = flags.nnext_nil ? S_P_START : S_FIX_WAIT;
      end
      S_P_START:  state_next = flags.aprev_nil ? S_OUT : S_P_WAIT;
      S_P_WAIT:   state_next = S_P_CHK;
      S_P_CHK:    state_next = flags.rd_free ? S_ABS2 : S_OUT;
      S_ABS2:     state_next = S_WA2;
      S_WA2: begin
        ret_next   = S_OUT;
        state_next = flags.nnext_nil ? S_OUT : S_FIX_WAIT;
      end
      S_FIX_WAIT: state_next = S_FIX;
      S_FIX:      state_next = ret;
      S_OUT:      if (!flags.out_busy) state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  // Drive datapath commands
  always_comb begin
    cmd.op   = OP_NONE;
    cmd.code = ST_OK;
    in_ready = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) cmd.op = OP_LATCH;
      end
      S_START: begin
        if (!flags.free_cmd) begin
          if (!heap_ready || flags.zero_req) begin
            cmd.op   = OP_SETST;
            cmd.code = ST_REJECTED;
          end
        end else if (!heap_ready || flags.off_bad) begin
          cmd.op   = OP_SETST;
          cmd.code = ST_IGNORED;
        end
      end
      S_A_CHK:    cmd.op = flags.fit ? OP_TAKE : OP_ADV;
      S_A_SPL:    if (flags.split_want) cmd.op = OP_GSTART;
      S_A_GRAB:   if (!flags.g_done) cmd.op = OP_GSTEP;
      S_A_WHOLE:  cmd.op = OP_WHOLE;
      S_A_WT:     cmd.op = OP_SPL_T;
      S_A_WB:     cmd.op = OP_SPL_B;
      S_G_CHK: begin
        if (flags.limit_bad) begin
          cmd.op   = OP_SETST;
          cmd.code = ST_EXHAUSTED;
        end else begin
          cmd.op = OP_GSTART;
        end
      end
      S_G_GRAB: begin
        if (!flags.g_done) begin
          cmd.op = OP_GSTEP;
        end else if (flags.g_nil) begin
          cmd.op   = OP_SETST;
          cmd.code = ST_TABLE_FULL;
        end else if (!flags.backing) begin
          cmd.op   = OP_SETST;
          cmd.code = ST_BACKING;
        end
      end
      S_G_WR:     cmd.op = OP_GROW;
      S_F_WAIT: begin
        if (flags.cur_nil) begin
          cmd.op   = OP_SETST;
          cmd.code = ST_IGNORED;
        end
      end
      S_F_CHK: begin
        if (!flags.off_hit) begin
          cmd.op = OP_ADV;
        end else if (flags.rd_free) begin
          cmd.op   = OP_SETST;
          cmd.code = ST_IGNORED;
        end else begin
          cmd.op = OP_FTAKE;
        end
      end
      S_F_WB:     cmd.op = OP_WA_NEXT;
      S_N_CHK:    if (flags.rd_free) cmd.op = OP_LOADN;
      S_ABS1:     cmd.op = OP_ABS;
      S_WA1:      cmd.op = OP_WA;
      S_P_START:  if (!flags.aprev_nil) cmd.op = OP_SWAP;
      S_P_CHK:    if (flags.rd_free) cmd.op = OP_LOADA;
      S_ABS2:     cmd.op = OP_ABS;
      S_WA2:      cmd.op = OP_WA;
      S_FIX:      cmd.op = OP_FIX;
      S_OUT:      if (!flags.out_busy) cmd.op = OP_PUB;
      default:    cmd.op = OP_NONE;
    endcase
  end

endmodule

`default_nettype wire

[rtl/core/ffha_dp.sv]
// Datapath of the allocator: descriptor memory, list pointers, counters, result word.
`default_nettype none

module ffha_dp
  import ffha_pkg::*;
#(
  parameter int unsigned MAX_BLOCKS = 256
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire dp_cmd_t     cmd,
  output dp_flags_t        flags,
  input  wire logic [32:0] arena_limit_pages,
  input  wire logic        command,
  input  wire logic [31:0] request_bytes,
  input  wire logic [43:0] free_offset,
  input  wire logic        backing_available,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       status,
  output logic [43:0]      payload_offset,
  output logic [32:0]      grown_pages,
  output logic [43:0]      grown_start,
  output logic [44:0]      used_bytes,
  output logic [44:0]      free_bytes,
  output logic [8:0]       live_allocations,
  output logic [32:0]      mapped_pages,
  output logic [44:0]      arena_end
);

  localparam int unsigned LW = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned AW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam logic [LW-1:0] NIL = LW'(MAX_BLOCKS);

  typedef struct packed {
    logic [43:0]   start;
    logic [43:0]   size;
    logic [43:0]   cap;
    logic          free;
    logic [LW-1:0] prev;
    logic [LW-1:0] next;
  } desc_t;

  desc_t mem [MAX_BLOCKS];
  desc_t rdat, arec, nrec, wr_data;
  desc_t freed, merged;
  logic  wr_en;
  logic [LW-1:0] wr_addr;
  logic [MAX_BLOCKS-1:0] in_use;

  logic [LW-1:0] cur, aidx, nidx, g, fixv, head, tail;
  logic          fixnext;
  logic          cmd_r, back;
  logic [32:0]   req;
  logic [43:0]   off;
  logic [44:0]   end_off;
  logic [32:0]   ptot;
  logic [44:0]   used, freet;
  logic [8:0]    allocs;
  status_t       res_status;
  logic [43:0]   res_off, res_gs;
  logic [32:0]   res_gp;

  logic [32:0]   req_in;
  logic [33:0]   psum;
  logic [PG_W-1:0] pages;
  logic [44:0]   grow_bytes;
  logic [43:0]   grow_cap;
  logic [32:0]   lim;
  logic [43:0]   req44, rem;
  logic [8:0]    allocs_inc;

  // Work out sizes for the word in hand
  always_comb begin
    req_in     = ({1'b0, request_bytes} + 33'(ALIGN_BYTES - 1)) & ~33'(ALIGN_BYTES - 1);
    psum       = {1'b0, req} + 34'(HEADER_BYTES + PAGE_BYTES - 1);
    pages      = psum[33:PAGE_SHIFT];
    grow_bytes = 45'(pages) << PAGE_SHIFT;
    grow_cap   = grow_bytes[43:0] - 44'(HEADER_BYTES);
    lim        = (arena_limit_pages < ARENA_PAGE_CAP) ? arena_limit_pages : ARENA_PAGE_CAP;
    req44      = {11'd0, req};
    rem        = arec.cap - req44;
    allocs_inc = (allocs < 9'd511) ? allocs + 9'd1 : allocs;
    // Block being freed, marked free
    freed      = rdat;
    freed.free = 1'b1;
    // Block after swallowing its successor
    merged      = arec;
    merged.cap  = arec.cap + 44'(HEADER_BYTES) + nrec.cap;
    merged.size = arec.cap + 44'(HEADER_BYTES) + nrec.cap;
    merged.next = nrec.next;
  end

  // Report status to the sequencer
  always_comb begin
    flags.cur_nil    = (cur == NIL);
    flags.fit        = rdat.free && (rdat.cap >= req44);
    flags.split_want = (rem >= 44'(SPLIT_MIN));
    flags.g_done     = (g == NIL) || !in_use[g[AW-1:0]];
    flags.g_nil      = (g == NIL);
    flags.limit_bad  = (ptot > lim) || (33'(pages) > (lim - ptot));
    flags.tail_nil   = (tail == NIL);
    flags.anext_nil  = (arec.next == NIL);
    flags.nnext_nil  = (nrec.next == NIL);
    flags.aprev_nil  = (arec.prev == NIL);
    flags.rd_free    = rdat.free;
    flags.off_hit    = ({1'b0, rdat.start} + 45'(HEADER_BYTES)) == {1'b0, off};
    flags.off_bad    = (off < 44'(HEADER_BYTES)) || ({1'b0, off} >= end_off);
    flags.zero_req   = (req == '0);
    flags.free_cmd   = (cmd_r == CMD_FREE);
    flags.backing    = back;
    flags.out_busy   = out_valid && !out_ready;
  end

  // Form the descriptor write
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = aidx;
    wr_data = arec;
    case (cmd.op)
      OP_WHOLE: begin
        wr_en        = 1'b1;
        wr_data.free = 1'b0;
        wr_data.size = arec.cap;
      end
      OP_SPL_T: begin
        wr_en         = 1'b1;
        wr_addr       = g;
        wr_data.start = arec.start + 44'(HEADER_BYTES) + req44;
        wr_data.size  = rem - 44'(HEADER_BYTES);
        wr_data.cap   = rem - 44'(HEADER_BYTES);
        wr_data.free  = 1'b1;
        wr_data.prev  = aidx;
        wr_data.next  = arec.next;
      end
      OP_SPL_B: begin
        wr_en        = 1'b1;
        wr_data.next = g;
        wr_data.cap  = req44;
        wr_data.size = req44;
        wr_data.free = 1'b0;
      end
      OP_FIX: begin
        wr_en   = 1'b1;
        wr_addr = cur;
        wr_data = rdat;
        if (fixnext) wr_data.next = fixv;
        else wr_data.prev = fixv;
      end
      OP_GROW: begin
        wr_en         = 1'b1;
        wr_addr       = g;
        wr_data.start = end_off[43:0];
        wr_data.size  = req44;
        wr_data.cap   = grow_cap;
        wr_data.free  = 1'b0;
        wr_data.prev  = tail;
        wr_data.next  = NIL;
      end
      OP_WA_NEXT, OP_WA: wr_en = 1'b1;
      default: wr_en = 1'b0;
    endcase
  end

  // Descriptor memory, one write and one registered read a cycle
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr[AW-1:0]] <= wr_data;
    rdat <= mem[cur[AW-1:0]];
  end

  // Control state: list ends, counters, slot use, result flag
  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= NIL;
      tail      <= NIL;
      end_off   <= '0;
      ptot      <= '0;
      used      <= '0;
      freet     <= '0;
      allocs    <= '0;
      in_use    <= '0;
      out_valid <= 1'b0;
    end else begin
      case (cmd.op)
        OP_TAKE:  freet <= freet - {1'b0, rdat.cap};
        OP_WHOLE: begin
          used   <= used + 45'(req);
          allocs <= allocs_inc;
        end
        OP_SPL_T: begin
          in_use[g[AW-1:0]] <= 1'b1;
          freet <= freet + {1'b0, rem} - 45'(HEADER_BYTES);
        end
        OP_SPL_B: begin
          used   <= used + 45'(req);
          allocs <= allocs_inc;
          if (arec.next == NIL) tail <= g;
        end
        OP_GROW: begin
          in_use[g[AW-1:0]] <= 1'b1;
          if (tail == NIL) head <= g;
          tail    <= g;
          end_off <= end_off + grow_bytes;
          ptot    <= ptot + 33'(pages);
          used    <= used + 45'(req);
          allocs  <= allocs_inc;
        end
        OP_FTAKE: begin
          if (used >= {1'b0, rdat.size}) used <= used - {1'b0, rdat.size};
          freet <= freet + {1'b0, rdat.cap};
          if (allocs != '0) allocs <= allocs - 9'd1;
        end
        OP_ABS: begin
          freet <= freet + 45'(HEADER_BYTES);
          in_use[nidx[AW-1:0]] <= 1'b0;
          if (nrec.next == NIL) tail <= aidx;
        end
        default: ;
      endcase
      // Raise on publish, drop once taken
      if (cmd.op == OP_PUB) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // Working registers and result word
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LATCH: begin
        cmd_r      <= command;
        req        <= req_in;
        off        <= free_offset;
        back       <= backing_available;
        cur        <= head;
        res_status <= ST_OK;
        res_off    <= '0;
        res_gp     <= '0;
        res_gs     <= '0;
      end
      OP_SETST:  res_status <= cmd.code;
      OP_ADV:    cur <= rdat.next;
      OP_TAKE: begin
        aidx <= cur;
        arec <= rdat;
      end
      OP_GSTART: g <= '0;
      OP_GSTEP:  g <= g + LW'(1);
      OP_WHOLE:  res_off <= arec.start + 44'(HEADER_BYTES);
      OP_SPL_B: begin
        res_off <= arec.start + 44'(HEADER_BYTES);
        cur     <= arec.next;
        fixv    <= g;
        fixnext <= 1'b0;
      end
      OP_GROW: begin
        res_off <= end_off[43:0] + 44'(HEADER_BYTES);
        res_gp  <= 33'(pages);
        res_gs  <= end_off[43:0];
        cur     <= tail;
        fixv    <= g;
        fixnext <= 1'b1;
      end
      OP_FTAKE: begin
        aidx <= cur;
        arec <= freed;
      end
      OP_WA_NEXT: cur <= arec.next;
      OP_LOADN: begin
        nrec <= rdat;
        nidx <= cur;
      end
      OP_ABS: begin
        arec    <= merged;
        cur     <= nrec.next;
        fixv    <= aidx;
        fixnext <= 1'b0;
      end
      OP_SWAP: begin
        nrec <= arec;
        nidx <= aidx;
        cur  <= arec.prev;
      end
      OP_LOADA: begin
        arec <= rdat;
        aidx <= cur;
      end
      OP_PUB: begin
        status           <= res_status;
        payload_offset   <= res_off;
        grown_pages      <= res_gp;
        grown_start      <= res_gs;
        used_bytes       <= used;
        free_bytes       <= freet;
        live_allocations <= allocs;
        mapped_pages     <= ptot;
        arena_end        <= end_off;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

[rtl/core/first_fit_heap_allocator.sv]
// Top level of the first-fit heap allocator: register port, sequencer and datapath.
// Use: one word on the input channel (in_valid/in_ready) is an allocate or a free
// command; each gives exactly one result word on the output channel
// (out_valid/out_ready) with a status, the payload offset, any growth and the
// usage counters after the command. Configuration goes through the APB port:
// heap_ready at address 0, arena_limit_pages at address 8; write only while idle.
// Flow: the list is walked one descriptor at a time, each with a registered memory
// read and a test of it; when a split or growth needs a new descriptor, a scan of
// up to MAX_BLOCKS slots finds a free one; writes and list fix-ups follow.
// One command is worked at a time; in_ready is high while the sequencer idles.
// The result sits in an output register, so a new command is taken while the
// previous result waits; a stalled receiver holds the result and, once the next
// one is finished, holds the sequencer too.
// Reset: synchronous, empties the list and clears all counters and use bits;
// heap_ready returns to 0 and arena_limit_pages to 2^32.
`default_nettype none

module first_fit_heap_allocator
  import ffha_pkg::*;
#(
  parameter int unsigned MAX_BLOCKS = 256
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic [63:0]      prdata,
  output logic             pready,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        command,
  input  wire logic [31:0] request_bytes,
  input  wire logic [43:0] free_offset,
  input  wire logic        backing_available,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       status,
  output logic [43:0]      payload_offset,
  output logic [32:0]      grown_pages,
  output logic [43:0]      grown_start,
  output logic [44:0]      used_bytes,
  output logic [44:0]      free_bytes,
  output logic [8:0]       live_allocations,
  output logic [32:0]      mapped_pages,
  output logic [44:0]      arena_end
);

  logic        heap_ready;
  logic [32:0] arena_limit_pages;
  dp_cmd_t     cmd;
  dp_flags_t   flags;
  logic        reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[3];

  // Take register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      heap_ready        <= 1'b0;
      arena_limit_pages <= 33'h1_0000_0000;
    end else if (psel && penable && pwrite) begin
      unique case (reg_sel)
        REG_HEAP_READY:  heap_ready        <= pwdata[0];
        REG_ARENA_LIMIT: arena_limit_pages <= pwdata[32:0];
        default: ;
      endcase
    end
  end

  // Return register reads
  always_comb begin
    unique case (reg_sel)
      REG_HEAP_READY:  prdata = {63'd0, heap_ready};
      REG_ARENA_LIMIT: prdata = {31'd0, arena_limit_pages};
      default:         prdata = '0;
    endcase
  end

  ffha_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .heap_ready (heap_ready),
    .flags      (flags),
    .cmd        (cmd)
  );

  ffha_dp #(
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_dp (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .flags             (flags),
    .arena_limit_pages (arena_limit_pages),
    .command           (command),
    .request_bytes     (request_bytes),
    .free_offset       (free_offset),
    .backing_available (backing_available),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .status            (status),
    .payload_offset    (payload_offset),
    .grown_pages       (grown_pages),
    .grown_start       (grown_start),
    .used_bytes        (used_bytes),
    .free_bytes        (free_bytes),
    .live_allocations  (live_allocations),
    .mapped_pages      (mapped_pages),
    .arena_end         (arena_end)
  );

endmodule

`default_nettype wire

[rtl/core/ffha_checker.sv]
// Port-level checks of the allocator result channel, bound to the top level.
`default_nettype none

module ffha_checker
  import ffha_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [2:0]  status,
  input wire logic [43:0] payload_offset,
  input wire logic [32:0] grown_pages,
  input wire logic [43:0] grown_start
);

  // Hold a stalled result word
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(payload_offset))
    else $error("result word changed while stalled");

  // Clear offsets on any failure
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != ST_OK) |-> (payload_offset == '0) && (grown_pages == '0)
      && (grown_start == '0))
    else $error("failed command reported an offset or growth");

  // Place a grown block's payload just past its header
  a_grow_place: assert property (@(posedge clk) disable iff (rst)
    out_valid && (grown_pages != '0) |->
      ({1'b0, payload_offset} == ({1'b0, grown_start} + 45'(HEADER_BYTES))))
    else $error("growth and payload offset disagree");

  // Keep status within its codes
  a_status: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status <= 3'(ST_TABLE_FULL)))
    else $error("status code out of range");

endmodule

bind first_fit_heap_allocator ffha_checker u_ffha_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .status         (status),
  .payload_offset (payload_offset),
  .grown_pages    (grown_pages),
  .grown_start    (grown_start)
);

`default_nettype wire
